### src/mlft_pkg.sv
// Shared types, codes and the hash function of the MAC learning filter table.
package mlft_pkg;

  localparam int unsigned TableEntriesDef = 256;
  localparam int unsigned MaxAw = 12;

  localparam logic [1:0] ModeFrame = 2'd0;
  localparam logic [1:0] ModeTick  = 2'd1;
  localparam logic [1:0] ModeClear = 2'd2;

  localparam logic CfgMaxAge   = 1'b0;
  localparam logic CfgScanStep = 1'b1;

  localparam logic [7:0]  MaxAgeRst   = 8'd30;
  localparam logic [12:0] ScanStepRst = 13'd25;
  localparam logic [15:0] HashMul     = 16'o67433;

  typedef struct packed {
    logic [1:0]  mode;
    logic [47:0] dest_mac;
    logic [47:0] src_mac;
  } in_word_t;

  typedef struct packed {
    logic forward;
    logic learned;
    logic done_res;
  } out_word_t;

  typedef struct packed {
    in_word_t         word;
    logic [MaxAw-1:0] src_home;
    logic [MaxAw-1:0] dst_home;
  } job_t;

  typedef struct packed {
    logic pop;
    logic init_busy;
  } back_ctl_t;

  // Home slot: only the low bits survive the table mask.
  function automatic logic [MaxAw-1:0] hash_home(logic [47:0] mac);
    logic [31:0]      prod;
    logic [MaxAw-1:0] sum;
    prod = 32'(mac[47:32]) * 32'(HashMul);
    sum  = mac[MaxAw-1:0] + mac[16 +: MaxAw] + prod[MaxAw-1:0];
    return sum;
  endfunction

endpackage

### src/mlft_ram.sv
// Generic single write port, single read port RAM with registered read data.
module mlft_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### src/mlft_front.sv
// Front part: accepts input words, computes home slots and queues the jobs.
module mlft_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mlft_pkg::in_word_t  in_word_i,
  input  mlft_pkg::back_ctl_t ctl_i,
  output logic                job_valid_o,
  output mlft_pkg::job_t      job_o
);

  mlft_pkg::job_t q_mem [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push;
  logic           pop;
  mlft_pkg::job_t new_job;

  assign in_stall_o  = (count_q == 2'd2) || ctl_i.init_busy;
  assign push        = in_valid_i && !in_stall_o;
  assign job_valid_o = (count_q != 2'd0);
  assign pop         = ctl_i.pop && job_valid_o;
  assign job_o       = q_mem[rd_ptr_q];

  always_comb begin
    new_job.word     = in_word_i;
    new_job.src_home = mlft_pkg::hash_home(in_word_i.src_mac);
    new_job.dst_home = mlft_pkg::hash_home(in_word_i.dest_mac);
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= new_job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### src/mlft_back.sv
// Back part: table sequencer, table memories, configuration and result register.
module mlft_back #(
  parameter int unsigned TABLE_ENTRIES = mlft_pkg::TableEntriesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  input  mlft_pkg::job_t       job_i,
  output mlft_pkg::back_ctl_t  ctl_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [12:0]          cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mlft_pkg::out_word_t  out_word_o
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned LW = AW + 1;
  localparam int unsigned MW = 8 + LW;
  localparam int unsigned SW = 14;
  localparam logic [LW-1:0] NLink = LW'(TABLE_ENTRIES);
  localparam logic [AW-1:0] LastSlot = AW'(TABLE_ENTRIES - 1);

  localparam logic [4:0] StInit   = 5'd0;
  localparam logic [4:0] StIdle   = 5'd1;
  localparam logic [4:0] StSRd    = 5'd2;
  localparam logic [4:0] StSChk   = 5'd3;
  localparam logic [4:0] StSWPrev = 5'd4;
  localparam logic [4:0] StPRd    = 5'd5;
  localparam logic [4:0] StPChk   = 5'd6;
  localparam logic [4:0] StDStart = 5'd7;
  localparam logic [4:0] StDRd    = 5'd8;
  localparam logic [4:0] StDChk   = 5'd9;
  localparam logic [4:0] StARd    = 5'd10;
  localparam logic [4:0] StAChk   = 5'd11;
  localparam logic [4:0] StANRd   = 5'd12;
  localparam logic [4:0] StANChk  = 5'd13;
  localparam logic [4:0] StANFree = 5'd14;
  localparam logic [4:0] StClr    = 5'd15;
  localparam logic [4:0] StDone   = 5'd16;

  logic [4:0]          state_q, state_d;
  mlft_pkg::job_t      job_q, job_d;
  logic [AW-1:0]       cur_q, cur_d;
  logic [AW-1:0]       prev_q, prev_d;
  logic [7:0]          prev_life_q, prev_life_d;
  logic [LW-1:0]       cnt_q, cnt_d;
  logic [LW-1:0]       pos_q, pos_d;
  logic [LW-1:0]       end_q, end_d;
  logic [LW-1:0]       scan_q, scan_d;
  logic                fwd_q, fwd_d;
  logic                lrn_q, lrn_d;
  logic [7:0]          max_age_q, max_age_d;
  logic [12:0]         step_q, step_d;
  logic                out_valid_q, out_valid_d;
  mlft_pkg::out_word_t out_q, out_d;

  logic          we_a, we_m;
  logic [AW-1:0] waddr, raddr;
  logic [47:0]   wdata_a, rdata_a;
  logic [MW-1:0] wdata_m, rdata_m;

  logic [7:0]    rlife;
  logic [LW-1:0] rlink;
  logic          nx_valid;
  logic [AW-1:0] nx_idx;
  logic [LW-1:0] cnt_inc;
  logic [AW-1:0] cur_inc;
  logic [7:0]    life_dec;
  logic [LW-1:0] scan_start;
  logic [SW-1:0] run_sum;

  mlft_ram #(.Width(48), .Depth(TABLE_ENTRIES)) u_addr_ram (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (wdata_a),
    .raddr_i (raddr),
    .rdata_o (rdata_a)
  );

  mlft_ram #(.Width(MW), .Depth(TABLE_ENTRIES)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (we_m),
    .waddr_i (waddr),
    .wdata_i (wdata_m),
    .raddr_i (raddr),
    .rdata_o (rdata_m)
  );

  assign rlife    = rdata_m[MW-1:LW];
  assign rlink    = rdata_m[LW-1:0];
  assign nx_valid = (rlink != '0) && (rlink <= NLink);
  assign nx_idx   = AW'(rlink - 1'b1);
  assign cnt_inc  = cnt_q + 1'b1;
  assign cur_inc  = cur_q + 1'b1;
  assign life_dec = rlife - 8'd1;

  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign out_word_o      = out_q;

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    prev_life_d = prev_life_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    end_d       = end_q;
    scan_d      = scan_q;
    fwd_d       = fwd_q;
    lrn_d       = lrn_q;
    max_age_d   = max_age_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ctl_o.pop       = 1'b0;
    ctl_o.init_busy = (state_q == StInit);
    we_a        = 1'b0;
    we_m        = 1'b0;
    waddr       = cur_q;
    raddr       = cur_q;
    wdata_a     = job_q.word.src_mac;
    wdata_m     = '0;
    scan_start  = (scan_q >= NLink) ? '0 : scan_q;
    run_sum     = SW'(scan_start) + SW'(step_q);

    if (cfg_valid_i) begin
      if (cfg_index_i == mlft_pkg::CfgMaxAge) begin
        max_age_d = cfg_data_i[7:0];
      end else begin
        step_d = cfg_data_i;
      end
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StInit: begin
        we_m    = 1'b1;
        waddr   = pos_q[AW-1:0];
        pos_d   = pos_q + 1'b1;
        if (pos_q[AW-1:0] == LastSlot) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        fwd_d = 1'b0;
        lrn_d = 1'b0;
        if (job_valid_i) begin
          ctl_o.pop = 1'b1;
          job_d     = job_i;
          cnt_d     = '0;
          pos_d     = '0;
          if (job_i.word.mode == mlft_pkg::ModeFrame) begin
            cur_d   = job_i.src_home[AW-1:0];
            state_d = StSRd;
          end else if (job_i.word.mode == mlft_pkg::ModeTick) begin
            pos_d   = scan_start;
            end_d   = (run_sum > SW'(TABLE_ENTRIES)) ? NLink : LW'(run_sum);
            scan_d  = (run_sum > SW'(TABLE_ENTRIES)) ? NLink : LW'(run_sum);
            state_d = StARd;
          end else if (job_i.word.mode == mlft_pkg::ModeClear) begin
            state_d = StClr;
          end else begin
            state_d = StDone;
          end
        end
      end
      StSRd: begin
        state_d = StSChk;
      end
      StSChk: begin
        if (rlife == 8'd0) begin
          we_a    = 1'b1;
          we_m    = 1'b1;
          wdata_m = {max_age_q, LW'(0)};
          lrn_d   = 1'b1;
          state_d = (cnt_q != '0) ? StSWPrev : StDStart;
        end else if (rdata_a == job_q.word.src_mac) begin
          we_m    = 1'b1;
          wdata_m = {max_age_q, rlink};
          lrn_d   = 1'b1;
          state_d = StDStart;
        end else begin
          prev_d      = cur_q;
          prev_life_d = rlife;
          cnt_d       = cnt_inc;
          if (nx_valid && (cnt_inc < NLink)) begin
            cur_d   = nx_idx;
            state_d = StSRd;
          end else begin
            cur_d   = cur_inc;
            state_d = StPRd;
          end
        end
      end
      StPRd: begin
        state_d = StPChk;
      end
      StPChk: begin
        if (rlife == 8'd0) begin
          we_a    = 1'b1;
          we_m    = 1'b1;
          wdata_m = {max_age_q, LW'(0)};
          lrn_d   = 1'b1;
          state_d = StSWPrev;
        end else if (cur_inc == prev_q) begin
          state_d = StDStart;
        end else begin
          cur_d   = cur_inc;
          state_d = StPRd;
        end
      end
      StSWPrev: begin
        we_m    = 1'b1;
        waddr   = prev_q;
        wdata_m = {prev_life_q, LW'(cur_q) + 1'b1};
        state_d = StDStart;
      end
      StDStart: begin
        if (job_q.word.dest_mac[7]) begin
          fwd_d   = 1'b1;
          state_d = StDone;
        end else begin
          cur_d   = job_q.dst_home[AW-1:0];
          cnt_d   = '0;
          state_d = StDRd;
        end
      end
      StDRd: begin
        state_d = StDChk;
      end
      StDChk: begin
        if (rlife == 8'd0) begin
          if (cnt_q != '0) begin
            we_m    = 1'b1;
            waddr   = prev_q;
            wdata_m = {prev_life_q, LW'(0)};
          end
          fwd_d   = 1'b1;
          state_d = StDone;
        end else if (rdata_a == job_q.word.dest_mac) begin
          fwd_d   = 1'b0;
          state_d = StDone;
        end else begin
          prev_d      = cur_q;
          prev_life_d = rlife;
          cnt_d       = cnt_inc;
          if (nx_valid && (cnt_inc < NLink)) begin
            cur_d   = nx_idx;
            state_d = StDRd;
          end else begin
            fwd_d   = 1'b1;
            state_d = StDone;
          end
        end
      end
      StARd: begin
        raddr = pos_q[AW-1:0];
        if (pos_q >= end_q) begin
          state_d = StDone;
        end else begin
          state_d = StAChk;
        end
      end
      StAChk: begin
        waddr = pos_q[AW-1:0];
        if (rlife == 8'd0) begin
          pos_d   = pos_q + 1'b1;
          state_d = StARd;
        end else if (life_dec != 8'd0) begin
          we_m    = 1'b1;
          wdata_m = {life_dec, rlink};
          pos_d   = pos_q + 1'b1;
          state_d = StARd;
        end else begin
          we_m    = 1'b1;
          wdata_m = {8'd0, rlink};
          if (nx_valid) begin
            cur_d   = nx_idx;
            state_d = StANRd;
          end else begin
            pos_d   = pos_q + 1'b1;
            state_d = StARd;
          end
        end
      end
      StANRd: begin
        state_d = StANChk;
      end
      StANChk: begin
        // The successor's whole entry moves into the expired slot.
        we_a    = 1'b1;
        we_m    = 1'b1;
        waddr   = pos_q[AW-1:0];
        wdata_a = rdata_a;
        wdata_m = rdata_m;
        state_d = StANFree;
      end
      StANFree: begin
        we_m    = 1'b1;
        wdata_m = {8'd0, rlink};
        pos_d   = pos_q + 1'b1;
        state_d = StARd;
      end
      StClr: begin
        we_m  = 1'b1;
        waddr = pos_q[AW-1:0];
        pos_d = pos_q + 1'b1;
        if (pos_q[AW-1:0] == LastSlot) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d      = 1'b1;
          out_d.forward    = fwd_q;
          out_d.learned    = lrn_q;
          out_d.done_res   = 1'b1;
          state_d          = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    job_q       <= job_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    prev_life_q <= prev_life_d;
    cnt_q       <= cnt_d;
    end_q       <= end_d;
    fwd_q       <= fwd_d;
    lrn_q       <= lrn_d;
    out_q       <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StInit;
      pos_q       <= '0;
      scan_q      <= '0;
      max_age_q   <= mlft_pkg::MaxAgeRst;
      step_q      <= mlft_pkg::ScanStepRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      scan_q      <= scan_d;
      max_age_q   <= max_age_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### src/mac_learning_filter_table_core.sv
// Top level of the MAC learning filter table: front queue and table back end.
//
// Input words (mode, dest_mac, src_mac) arrive on in_valid_i/in_stall_o and
// are taken when valid is high and stall is low. The front computes both home
// slots and holds up to two words in a queue, so it keeps taking words while
// the back end works on the table. Each word yields exactly one result word
// (forward, learned, done_res) on out_valid_o/out_stall_i, in input order.
// A frame reads each source chain entry, probe slot and destination chain
// entry in turn through the table memory's single read port, and links a
// newly taken slot to its predecessor. A tick ages the slots of its scan
// window one at a time and moves the successor of each expired entry into
// its slot. A clear writes one slot a cycle. After reset the back end first
// zeroes the lifetime table, during which in_stall_o is high;
// configuration writes on cfg_valid_i/cfg_ready_o are always taken. When the
// receiver stalls, the result word is held in the output register and the
// next item waits in the back end while the queue keeps filling.
module mac_learning_filter_table_core #(
  parameter int unsigned TABLE_ENTRIES = mlft_pkg::TableEntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mlft_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mlft_pkg::out_word_t out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [12:0]         cfg_data_i
);

  mlft_pkg::back_ctl_t ctl;
  mlft_pkg::job_t      job;
  logic                job_valid;

  mlft_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .ctl_i       (ctl),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  mlft_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .ctl_o       (ctl),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

### tb/sv/mac_learning_filter_table_core_test.sv
// Self-checking test of the MAC learning filter table core against its own table predictor.
module mac_learning_filter_table_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Entries = 256;
  localparam int unsigned NoSlot = Entries;
  localparam int unsigned LimitCycles = 20000000;
  localparam logic [1:0] ModeSpare = 2'd3;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  mlft_pkg::in_word_t in_word_i;
  logic out_valid_o;
  logic out_stall_i;
  mlft_pkg::out_word_t out_word_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic cfg_index_i;
  logic [12:0] cfg_data_i;

  mac_learning_filter_table_core #(.TABLE_ENTRIES(Entries)) i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_word_i(in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o(out_word_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  // Predictor copy of the table state and the two registers.
  logic [47:0] tbl_addr[Entries];
  logic [7:0] tbl_life[Entries];
  logic [8:0] tbl_link[Entries];
  int unsigned scan_pos;
  logic [7:0] age_limit;
  logic [12:0] slots_per_tick;

  mlft_pkg::in_word_t pending_words[$];
  mlft_pkg::out_word_t expected_words[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned learned_count = 0;
  int unsigned dropped_count = 0;
  bit idling_on = 1'b1;
  bit in_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;

  // Pool of source addresses reused so that frames hit, chain and age entries.
  logic [47:0] mac_pool[64];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LimitCycles) begin
      $display("mac_learning_filter_table_core_test NOT OK");
      $finish;
    end
  end

  function automatic int unsigned home_of(logic [47:0] mac);
    logic [31:0] acc;
    acc = 32'(mac[15:0]) + 32'(mac[31:16]) + 32'(mac[47:32]) * 32'(mlft_pkg::HashMul);
    return acc & (Entries - 1);
  endfunction

  function automatic int unsigned succ_of(int unsigned i);
    if (tbl_link[i] == 0 || tbl_link[i] > Entries) begin
      return NoSlot;
    end
    return tbl_link[i] - 1;
  endfunction

  function automatic void claim_slot(int unsigned e, int unsigned prev, logic [47:0] mac);
    tbl_addr[e] = mac;
    tbl_link[e] = '0;
    if (prev != NoSlot) begin
      tbl_link[prev] = 9'(e + 1);
    end
  endfunction

  // Walks the chain from the home slot; with grab set a miss allocates a slot.
  function automatic int unsigned find_slot(logic [47:0] mac, bit grab);
    int unsigned cur;
    int unsigned prev;
    int unsigned n;
    int unsigned e;
    cur = home_of(mac);
    prev = NoSlot;
    n = 0;
    while (cur != NoSlot && n < Entries) begin
      if (tbl_life[cur] == 0) begin
        if (grab) begin
          claim_slot(cur, prev, mac);
          return cur;
        end
        // A stale entry cuts the chain during a destination lookup.
        if (prev != NoSlot) begin
          tbl_link[prev] = '0;
        end
        return NoSlot;
      end
      if (tbl_addr[cur] == mac) begin
        return cur;
      end
      prev = cur;
      cur = succ_of(cur);
      n++;
    end
    if (!grab || prev == NoSlot) begin
      return NoSlot;
    end
    e = (prev + 1) % Entries;
    while (tbl_life[e] != 0) begin
      e = (e + 1) % Entries;
      if (e == prev) begin
        return NoSlot;
      end
    end
    claim_slot(e, prev, mac);
    return e;
  endfunction

  function automatic void age_slots();
    int unsigned e;
    int unsigned stop;
    int unsigned nx;
    if (scan_pos >= Entries) begin
      scan_pos = 0;
    end
    e = scan_pos;
    stop = scan_pos + slots_per_tick;
    if (stop > Entries) begin
      stop = Entries;
    end
    scan_pos = stop;
    for (; e < stop; e++) begin
      if (tbl_life[e] != 0) begin
        tbl_life[e] = tbl_life[e] - 1;
        if (tbl_life[e] == 0) begin
          nx = succ_of(e);
          // An expired entry is replaced by its chain successor.
          if (nx != NoSlot) begin
            tbl_addr[e] = tbl_addr[nx];
            tbl_life[e] = tbl_life[nx];
            tbl_link[e] = tbl_link[nx];
            tbl_life[nx] = '0;
          end
        end
      end
    end
  endfunction

  function automatic mlft_pkg::out_word_t filter_word(mlft_pkg::in_word_t w);
    mlft_pkg::out_word_t r;
    int unsigned s;
    r = '0;
    r.done_res = 1'b1;
    case (w.mode)
      mlft_pkg::ModeFrame: begin
        s = find_slot(w.src_mac, 1'b1);
        if (s != NoSlot) begin
          tbl_life[s] = age_limit;
          r.learned = 1'b1;
        end
        if (w.dest_mac[7]) begin
          r.forward = 1'b1;
        end else begin
          r.forward = (find_slot(w.dest_mac, 1'b0) == NoSlot);
        end
      end
      mlft_pkg::ModeTick: begin
        age_slots();
      end
      mlft_pkg::ModeClear: begin
        for (int i = 0; i < Entries; i++) begin
          tbl_life[i] = '0;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Acceptance is taken at the rising edge, where the handshake is defined.
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_words.push_back(filter_word(in_word_i));
      words_sent <= words_sent + 1;
    end
  end

  // Driver: presents queued words and receiver stalls, changes only at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (idling_on && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(1, 16);
          in_valid_i <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_word_i <= pending_words.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall_i <= 1'b1;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(1, 16);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Monitor: checks each result word at the rising edge.
  always @(posedge clk_i) begin
    mlft_pkg::out_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        $error("result word with none expected: %b", out_word_o);
        errors++;
      end else begin
        exp_w = expected_words.pop_front();
        words_checked <= words_checked + 1;
        if (exp_w.learned) learned_count <= learned_count + 1;
        if (!exp_w.forward && exp_w.learned) dropped_count <= dropped_count + 1;
        if (out_word_o.forward !== exp_w.forward) begin
          $error("forward: expected %0b actual %0b", exp_w.forward, out_word_o.forward);
          errors++;
        end
        if (out_word_o.learned !== exp_w.learned) begin
          $error("learned: expected %0b actual %0b", exp_w.learned, out_word_o.learned);
          errors++;
        end
        if (out_word_o.done_res !== exp_w.done_res) begin
          $error("done_res: expected %0b actual %0b", exp_w.done_res, out_word_o.done_res);
          errors++;
        end
      end
    end
  end

  function automatic mlft_pkg::in_word_t make_word(logic [1:0] m, logic [47:0] d,
                                                   logic [47:0] s);
    mlft_pkg::in_word_t w;
    w.mode = m;
    w.dest_mac = d;
    w.src_mac = s;
    return w;
  endfunction

  function automatic logic [47:0] rand_mac();
    return {16'($urandom), $urandom};
  endfunction

  // Picks a pool address, a fully random one, or one sharing a home slot.
  function automatic logic [47:0] pick_mac();
    logic [47:0] m;
    case ($urandom_range(0, 5))
      0: m = rand_mac();
      1: begin
        m = mac_pool[$urandom_range(0, 63)];
        m[15:8] = m[15:8] + 8'($urandom_range(1, 255));
      end
      default: m = mac_pool[$urandom_range(0, 63)];
    endcase
    return m;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid_i || expected_words.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [12:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == mlft_pkg::CfgMaxAge) begin
      age_limit = val[7:0];
    end else begin
      slots_per_tick = val;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int unsigned count);
    logic [47:0] d;
    int unsigned r;
    for (int unsigned k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      d = pick_mac();
      if ($urandom_range(0, 3) == 0) d[7] = ~d[7];
      if (r < 75) begin
        pending_words.push_back(make_word(mlft_pkg::ModeFrame, d, pick_mac()));
      end else if (r < 95) begin
        pending_words.push_back(make_word(mlft_pkg::ModeTick, rand_mac(), rand_mac()));
      end else if (r < 97) begin
        pending_words.push_back(make_word(mlft_pkg::ModeClear, rand_mac(), rand_mac()));
      end else begin
        pending_words.push_back(make_word(ModeSpare, rand_mac(), rand_mac()));
      end
    end
  endtask

  initial begin
    logic [47:0] a;
    for (int i = 0; i < Entries; i++) begin
      tbl_addr[i] = '0;
      tbl_life[i] = '0;
      tbl_link[i] = '0;
    end
    scan_pos = 0;
    age_limit = mlft_pkg::MaxAgeRst;
    slots_per_tick = mlft_pkg::ScanStepRst;
    for (int i = 0; i < 64; i++) begin
      mac_pool[i] = rand_mac();
      mac_pool[i][7] = (i % 4 == 0);
    end
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = mlft_pkg::CfgMaxAge;
    cfg_data_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: field extremes, every mode, collisions, stale chains.
    a = 48'h0000_0000_0000;
    pending_words.push_back(make_word(mlft_pkg::ModeFrame, 48'hFFFF_FFFF_FFFF, a));
    pending_words.push_back(make_word(mlft_pkg::ModeFrame, a, 48'hFFFF_FFFF_FFFF));
    pending_words.push_back(make_word(mlft_pkg::ModeFrame, 48'hFFFF_FFFF_FFFF, a));
    pending_words.push_back(make_word(mlft_pkg::ModeFrame, 48'hFFFF_FFFF_FF7F, a));
    // Two sources with the same home slot build a chain.
    pending_words.push_back(make_word(mlft_pkg::ModeFrame, a, 48'h0000_0001_0000));
    pending_words.push_back(make_word(mlft_pkg::ModeFrame, 48'h0000_0001_0000,
                                      48'h0000_0000_0001));
    pending_words.push_back(make_word(mlft_pkg::ModeFrame, 48'h0000_0000_0001,
                                      48'h0000_0002_0000));
    pending_words.push_back(make_word(mlft_pkg::ModeTick, 48'hFFFF_FFFF_FFFF,
                                      48'hFFFF_FFFF_FFFF));
    pending_words.push_back(make_word(ModeSpare, 48'hAAAA_5555_AAAA, 48'h5555_AAAA_5555));
    pending_words.push_back(make_word(mlft_pkg::ModeClear, a, a));
    pending_words.push_back(make_word(mlft_pkg::ModeFrame, 48'h0000_0000_0001, a));
    wait_drained();

    // Short lifetime and a scan step past the table end: a tick runs to the last slot.
    write_reg(mlft_pkg::CfgMaxAge, 13'd1);
    write_reg(mlft_pkg::CfgScanStep, 13'd4096);
    pending_words.push_back(make_word(mlft_pkg::ModeFrame, a, 48'h0000_0001_0000));
    pending_words.push_back(make_word(mlft_pkg::ModeFrame, a, 48'h0000_0000_0001));
    pending_words.push_back(make_word(mlft_pkg::ModeFrame, a, 48'h0000_0002_0000));
    pending_words.push_back(make_word(mlft_pkg::ModeTick, a, a));
    pending_words.push_back(make_word(mlft_pkg::ModeFrame, 48'h0000_0000_0001,
                                      48'h0000_0003_0000));
    pending_words.push_back(make_word(mlft_pkg::ModeFrame, 48'h0000_0001_0000, a));
    wait_drained();
    // A zero lifetime leaves the entry free while still reporting it learned.
    write_reg(mlft_pkg::CfgMaxAge, 13'd0);
    pending_words.push_back(make_word(mlft_pkg::ModeFrame, 48'h0000_0000_0009,
                                      48'h0000_0000_0009));
    wait_drained();

    // Fill the table completely so the probe wraps and reports it full.
    write_reg(mlft_pkg::CfgMaxAge, 13'd255);
    write_reg(mlft_pkg::CfgScanStep, 13'd1);
    pending_words.push_back(make_word(mlft_pkg::ModeClear, a, a));
    for (int i = 0; i < 260; i++) begin
      pending_words.push_back(make_word(mlft_pkg::ModeFrame, 48'h0000_0000_0080,
                                        48'(i) << 16));
    end
    pending_words.push_back(make_word(mlft_pkg::ModeClear, a, a));
    wait_drained();

    // Random phases over several register settings.
    write_reg(mlft_pkg::CfgMaxAge, 13'd3);
    write_reg(mlft_pkg::CfgScanStep, 13'd64);
    random_phase(450);
    wait_drained();
    write_reg(mlft_pkg::CfgMaxAge, 13'd12);
    write_reg(mlft_pkg::CfgScanStep, 13'd7);
    random_phase(450);
    wait_drained();
    write_reg(mlft_pkg::CfgMaxAge, 13'($urandom_range(1, 255)));
    write_reg(mlft_pkg::CfgScanStep, 13'($urandom_range(1, 4096)));
    random_phase(400);
    wait_drained();
    // Last stretch with no idling on either side.
    idling_on = 1'b0;
    write_reg(mlft_pkg::CfgMaxAge, 13'd2);
    write_reg(mlft_pkg::CfgScanStep, 13'd256);
    random_phase(150);
    wait_drained();

    $display("Covered %0d words, %0d results checked (%0d learned, %0d local drops).",
             words_sent, words_checked, learned_count, dropped_count);
    $display("Register settings swept lifetimes 0 to 255 and scan steps 1 to 4096.");
    if (errors == 0) begin
      $display("mac_learning_filter_table_core_test OK");
    end else begin
      $display("mac_learning_filter_table_core_test NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
src/mlft_pkg.sv
src/mlft_ram.sv
src/mlft_front.sv
src/mlft_back.sv
src/mac_learning_filter_table_core.sv
tb/sv/mac_learning_filter_table_core_test.sv
